### hdl/sacl_pkg.sv
// ----------------------------------------------------------------------------
// Set-associative LFU cache tag engine: shared package
// Field widths, codes and the command and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package sacl_pkg;

    // Default structural parameters
    localparam int DEF_LOG_SETS       = 8;
    localparam int DEF_WAYS           = 4;
    localparam int DEF_LOG_LINE_BYTES = 6;
    localparam int DEF_ADDR_BITS      = 48;
    localparam int DEF_MAX_RUN        = 64;
    localparam int DEF_COUNT_BITS     = 16;

    // Fixed field widths of the ports
    localparam int LEN_W    = 7;
    localparam int STATUS_W = 2;
    localparam int SET_W    = 8;
    localparam int WAY_FW   = 2;
    localparam int OFF_W    = 6;
    localparam int TOTAL_W  = 64;
    localparam int MODE_W   = 2;
    localparam int LES_W    = 3;
    localparam int CFG_IDX_W = 2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_CACHED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BYPASS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

    // Cache mode codes; the spare code behaves as caching mode.
    localparam logic [MODE_W-1:0] MODE_NONE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RESIDENT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CACHE    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd2;

    typedef struct packed {
        logic sweep;        // write an empty row during the reset pass
        logic load;         // take a new run
        logic emit_single;  // emit error or bypass result
        logic rd_en;        // read the set row
        logic update;       // resolve the piece, write back, emit
    } sacl_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic range_err;
        logic bypass;
        logic len_zero;
        logic out_free;
        logic last;
    } sacl_stat_t;

endpackage

### hdl/sacl_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read that holds its
// data while no read is requested.
// ----------------------------------------------------------------------------
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/sacl_ctrl.sv
// ----------------------------------------------------------------------------
// Tag engine controller
// Sequences each run: range and mode check, then a read and an update
// step for every line piece.
// ----------------------------------------------------------------------------
module sacl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sacl_pkg::sacl_stat_t stat,
    output sacl_pkg::sacl_cmd_t  cmd
);
    import sacl_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_READ,
        S_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        in_ready        = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                // One empty row per set after reset.
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.range_err || stat.bypass)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit_single = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else if (stat.len_zero)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (stat.out_free)
                begin
                    cmd.update = 1'b1;
                    state_next = stat.last ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/sacl_dp.sv
// ----------------------------------------------------------------------------
// Tag engine datapath
// Configuration registers, run registers, tag and use-count store, valid
// bits, way selection, running totals and the output register.
// ----------------------------------------------------------------------------
module sacl_dp #(
    parameter int LOG_SETS       = sacl_pkg::DEF_LOG_SETS,
    parameter int WAYS           = sacl_pkg::DEF_WAYS,
    parameter int LOG_LINE_BYTES = sacl_pkg::DEF_LOG_LINE_BYTES,
    parameter int ADDR_BITS      = sacl_pkg::DEF_ADDR_BITS,
    parameter int MAX_RUN        = sacl_pkg::DEF_MAX_RUN,
    parameter int COUNT_BITS     = sacl_pkg::DEF_COUNT_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ADDR_BITS:0]              cfg_data,
    input  logic [ADDR_BITS-1:0]            start_index,
    input  logic [sacl_pkg::LEN_W-1:0]      run_length,
    input  sacl_pkg::sacl_cmd_t             cmd,
    output sacl_pkg::sacl_stat_t            stat,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [sacl_pkg::STATUS_W-1:0]   status,
    output logic                            is_hit,
    output logic [sacl_pkg::SET_W-1:0]      set_number,
    output logic [sacl_pkg::WAY_FW-1:0]     way_number,
    output logic [sacl_pkg::OFF_W-1:0]      line_offset,
    output logic [sacl_pkg::LEN_W-1:0]      piece_length,
    output logic [ADDR_BITS-1:0]            fill_line_index,
    output logic [sacl_pkg::TOTAL_W-1:0]    hit_total,
    output logic [sacl_pkg::TOTAL_W-1:0]    access_total,
    output logic                            last_piece
);
    import sacl_pkg::*;

    localparam int NSETS   = 1 << LOG_SETS;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int VLD_OFS = ADDR_BITS + COUNT_BITS;
    localparam int ENT_W   = ADDR_BITS + COUNT_BITS + 1;
    localparam int ROW_W   = WAYS * ENT_W;
    localparam int LLS_W   = $clog2(LOG_LINE_BYTES + 1);
    localparam logic [COUNT_BITS-1:0] USE_MAX = '1;

    // Configuration
    logic [MODE_W-1:0]    mode_reg;
    logic [LES_W-1:0]     les_reg;
    logic [ADDR_BITS:0]   limit_reg;

    // Run in progress
    logic [ADDR_BITS-1:0] idx_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [TOTAL_W-1:0]   hits_reg;
    logic [TOTAL_W-1:0]   acc_reg;
    logic [LOG_SETS-1:0]  sweep_reg;

    // Output register
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic                 is_hit_reg;
    logic [SET_W-1:0]     set_reg;
    logic [WAY_FW-1:0]    way_reg;
    logic [OFF_W-1:0]     off_reg;
    logic [LEN_W-1:0]     piece_reg;
    logic [ADDR_BITS-1:0] fill_reg;
    logic [TOTAL_W-1:0]   hit_tot_reg;
    logic [TOTAL_W-1:0]   acc_tot_reg;
    logic                 last_reg;

    logic [LEN_W-1:0]     len_clamped;
    logic [LLS_W-1:0]     lls;
    logic [ADDR_BITS-1:0] off_mask;
    logic [ADDR_BITS-1:0] tag_keep;
    logic [ADDR_BITS-1:0] off_full;
    logic [ADDR_BITS-1:0] piece_full;
    logic [ADDR_BITS-1:0] set_shift;
    logic [LOG_SETS-1:0]  set_idx;
    logic [ADDR_BITS-1:0] tag;
    logic [LEN_W-1:0]     piece;
    logic [LEN_W-1:0]     len_next;
    logic [ADDR_BITS:0]   run_end;
    logic [ROW_W-1:0]     rd_row;
    logic [ROW_W-1:0]     wr_row;
    logic                 ram_wr_en;
    logic [LOG_SETS-1:0]  ram_wr_addr;
    logic [ROW_W-1:0]     ram_wr_data;
    logic [WAYS-1:0]      row_valid;
    logic                 hit;
    logic [WAY_W-1:0]     hit_way;
    logic [WAY_W-1:0]     victim;
    logic [WAY_W-1:0]     way_sel;
    logic                 any_invalid;
    logic [COUNT_BITS-1:0] best_cnt;
    logic [COUNT_BITS-1:0] sel_cnt;
    logic [TOTAL_W-1:0]   hits_next;
    logic [SET_W+LOG_SETS-1:0] set_ext;
    logic [WAY_FW+WAY_W-1:0]   way_ext;
    logic [OFF_W+ADDR_BITS-1:0] off_ext;

    assign len_clamped = (int'(run_length) > MAX_RUN) ? LEN_W'(MAX_RUN) : run_length;

    // Line geometry from the element size
    always_comb
    begin
        if (int'(les_reg) > LOG_LINE_BYTES)
        begin
            lls = '0;
        end
        else
        begin
            lls = LLS_W'(LOG_LINE_BYTES - int'(les_reg));
        end
    end

    assign off_mask   = (ADDR_BITS'(1) << lls) - ADDR_BITS'(1);
    assign tag_keep   = ~((ADDR_BITS'(1) << (int'(lls) + LOG_SETS)) - ADDR_BITS'(1));
    assign off_full   = idx_reg & off_mask;
    assign piece_full = (ADDR_BITS'(1) << lls) - off_full;
    assign set_shift  = idx_reg >> lls;
    assign set_idx    = set_shift[LOG_SETS-1:0];
    assign tag        = idx_reg & tag_keep;
    assign piece      = (piece_full > ADDR_BITS'(len_reg)) ? len_reg : piece_full[LEN_W-1:0];
    assign len_next   = len_reg - piece;
    assign run_end    = {1'b0, idx_reg} + (ADDR_BITS + 1)'(len_reg);

    assign stat.sweep_last = (sweep_reg == LOG_SETS'(NSETS - 1));
    assign stat.range_err  = run_end > limit_reg;
    assign stat.bypass     = (mode_reg == MODE_NONE) || (mode_reg == MODE_RESIDENT);
    assign stat.len_zero   = (len_reg == '0);
    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.last       = (len_next == '0);

    // The reset pass writes empty rows; otherwise the updated row goes back.
    assign ram_wr_en   = cmd.update || cmd.sweep;
    assign ram_wr_addr = cmd.sweep ? sweep_reg : set_idx;
    assign ram_wr_data = cmd.sweep ? '0 : wr_row;

    sacl_ram #(
        .WIDTH(ROW_W),
        .DEPTH(NSETS)
    ) u_tag_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (cmd.rd_en),
        .rd_addr(set_idx),
        .rd_data(rd_row)
    );

    // Tag match, first invalid way, else least used way (lowest on ties)
    always_comb
    begin
        hit         = 1'b0;
        hit_way     = '0;
        any_invalid = 1'b0;
        victim      = '0;
        best_cnt    = rd_row[ADDR_BITS +: COUNT_BITS];
        for (int w = 0; w < WAYS; w++)
        begin
            row_valid[w] = rd_row[w*ENT_W + VLD_OFS];
        end
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit && row_valid[w] && (rd_row[w*ENT_W +: ADDR_BITS] == tag))
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (!row_valid[w])
            begin
                any_invalid = 1'b1;
                victim      = WAY_W'(w);
            end
        end
        if (!any_invalid)
        begin
            for (int w = 1; w < WAYS; w++)
            begin
                if (rd_row[w*ENT_W + ADDR_BITS +: COUNT_BITS] < best_cnt)
                begin
                    best_cnt = rd_row[w*ENT_W + ADDR_BITS +: COUNT_BITS];
                    victim   = WAY_W'(w);
                end
            end
        end
        way_sel = hit ? hit_way : victim;
        sel_cnt = rd_row[int'(way_sel)*ENT_W + ADDR_BITS +: COUNT_BITS];
        wr_row  = rd_row;
        if (hit)
        begin
            if (sel_cnt != USE_MAX)
            begin
                wr_row[int'(way_sel)*ENT_W + ADDR_BITS +: COUNT_BITS] =
                    sel_cnt + COUNT_BITS'(1);
            end
        end
        else
        begin
            wr_row[int'(way_sel)*ENT_W +: ADDR_BITS]              = tag;
            wr_row[int'(way_sel)*ENT_W + ADDR_BITS +: COUNT_BITS] = '0;
            wr_row[int'(way_sel)*ENT_W + VLD_OFS]                 = 1'b1;
        end
    end

    assign hits_next = hit ? (hits_reg + TOTAL_W'(piece)) : hits_reg;
    assign set_ext   = {{SET_W{1'b0}}, set_idx};
    assign way_ext   = {{WAY_FW{1'b0}}, way_sel};
    assign off_ext   = {{OFF_W{1'b0}}, off_full};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_CACHE;
            les_reg       <= '0;
            limit_reg     <= {1'b1, {ADDR_BITS{1'b0}}};
            hits_reg      <= '0;
            acc_reg       <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_MODE:  mode_reg  <= cfg_data[MODE_W-1:0];
                    REG_LES:   les_reg   <= cfg_data[LES_W-1:0];
                    REG_LIMIT: limit_reg <= cfg_data;
                    default:   ;
                endcase
            end
            if (cmd.sweep)
            begin
                sweep_reg <= sweep_reg + LOG_SETS'(1);
            end
            if (cmd.load)
            begin
                acc_reg <= acc_reg + TOTAL_W'(len_clamped);
            end
            if (cmd.update)
            begin
                hits_reg <= hits_next;
            end
            if (cmd.emit_single || cmd.update)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Run and output payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg <= start_index;
            len_reg <= len_clamped;
        end
        if (cmd.update)
        begin
            idx_reg <= idx_reg + ADDR_BITS'(piece);
            len_reg <= len_next;
        end
        if (cmd.emit_single)
        begin
            status_reg  <= stat.range_err ? ST_RANGE : ST_BYPASS;
            is_hit_reg  <= 1'b0;
            set_reg     <= '0;
            way_reg     <= '0;
            off_reg     <= '0;
            piece_reg   <= stat.range_err ? '0 : len_reg;
            fill_reg    <= '0;
            hit_tot_reg <= hits_reg;
            acc_tot_reg <= acc_reg;
            last_reg    <= 1'b1;
        end
        else if (cmd.update)
        begin
            status_reg  <= ST_CACHED;
            is_hit_reg  <= hit;
            set_reg     <= set_ext[SET_W-1:0];
            way_reg     <= way_ext[WAY_FW-1:0];
            off_reg     <= off_ext[OFF_W-1:0];
            piece_reg   <= piece;
            fill_reg    <= idx_reg & ~off_mask;
            hit_tot_reg <= hits_next;
            acc_tot_reg <= acc_reg;
            last_reg    <= stat.last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign is_hit          = is_hit_reg;
    assign set_number      = set_reg;
    assign way_number      = way_reg;
    assign line_offset     = off_reg;
    assign piece_length    = piece_reg;
    assign fill_line_index = fill_reg;
    assign hit_total       = hit_tot_reg;
    assign access_total    = acc_tot_reg;
    assign last_piece      = last_reg;

endmodule

### hdl/set_assoc_lfu_cache_tag_engine.sv
// ----------------------------------------------------------------------------
// Set-associative LFU cache tag engine
// Looks up runs of elements in a four-way tag store and reports one result
// per line piece, with LFU refill on a miss.
// ----------------------------------------------------------------------------
// A run (start_index, run_length) is accepted on the in_valid/in_ready
// transfer. The engine then checks the run against element_limit and the
// cache mode; an out-of-range or bypass run gives its one result once the
// output register is free. In caching mode the run is cut at line
// boundaries and each piece takes two steps: reading its set row from
// the tag RAM, then comparing tags, picking the way and writing the row
// back. One run is handled at a time. Results leave through an output
// register on out_valid/out_ready; while the receiver stalls, the engine
// holds at the next piece and keeps its state. hit_total is the hit
// counter after the piece shown; access_total already counts the whole
// run. After reset the engine writes an empty row to each of the 256
// sets, one per cycle, with in_ready low; it also zeroes both totals and
// restores the register defaults: caching mode, one-byte elements, the
// full element limit. The configuration channel always accepts and must
// only be used while the engine is idle.
// ----------------------------------------------------------------------------
module set_assoc_lfu_cache_tag_engine #(
    parameter int LOG_SETS       = sacl_pkg::DEF_LOG_SETS,
    parameter int WAYS           = sacl_pkg::DEF_WAYS,
    parameter int LOG_LINE_BYTES = sacl_pkg::DEF_LOG_LINE_BYTES,
    parameter int ADDR_BITS      = sacl_pkg::DEF_ADDR_BITS,
    parameter int MAX_RUN        = sacl_pkg::DEF_MAX_RUN,
    parameter int COUNT_BITS     = sacl_pkg::DEF_COUNT_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ADDR_BITS:0]              cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ADDR_BITS-1:0]            start_index,
    input  logic [sacl_pkg::LEN_W-1:0]      run_length,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sacl_pkg::STATUS_W-1:0]   status,
    output logic                            is_hit,
    output logic [sacl_pkg::SET_W-1:0]      set_number,
    output logic [sacl_pkg::WAY_FW-1:0]     way_number,
    output logic [sacl_pkg::OFF_W-1:0]      line_offset,
    output logic [sacl_pkg::LEN_W-1:0]      piece_length,
    output logic [ADDR_BITS-1:0]            fill_line_index,
    output logic [sacl_pkg::TOTAL_W-1:0]    hit_total,
    output logic [sacl_pkg::TOTAL_W-1:0]    access_total,
    output logic                            last_piece
);
    import sacl_pkg::*;

    sacl_cmd_t  cmd;
    sacl_stat_t stat;

    // Registers are simple flops, so a write is always taken at once.
    assign cfg_ready = 1'b1;

    sacl_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sacl_dp #(
        .LOG_SETS      (LOG_SETS),
        .WAYS          (WAYS),
        .LOG_LINE_BYTES(LOG_LINE_BYTES),
        .ADDR_BITS     (ADDR_BITS),
        .MAX_RUN       (MAX_RUN),
        .COUNT_BITS    (COUNT_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .start_index    (start_index),
        .run_length     (run_length),
        .cmd            (cmd),
        .stat           (stat),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .status         (status),
        .is_hit         (is_hit),
        .set_number     (set_number),
        .way_number     (way_number),
        .line_offset    (line_offset),
        .piece_length   (piece_length),
        .fill_line_index(fill_line_index),
        .hit_total      (hit_total),
        .access_total   (access_total),
        .last_piece     (last_piece)
    );

    // A run is accepted only when the engine is idle, so it is busy next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("engine accepted a run and stayed idle");

    // Error and bypass results always close their run.
    a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_RANGE || status == ST_BYPASS) |-> last_piece)
        else $error("single result not marked last");

    // A cached piece always serves at least one element.
    a_piece_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_CACHED |-> piece_length != '0)
        else $error("empty cached piece");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the set-associative LFU cache tag engine
// Sends runs of element reads under several register settings and compares
// every result transfer against a behavioural model of the tag store, its
// LFU refill policy and its running totals.
// ----------------------------------------------------------------------------
module tb;
    import sacl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSETS = 256;
    localparam int NWAYS = 4;
    localparam logic [15:0] USE_MAX = 16'hFFFF;

    // One expected result transfer.
    typedef struct packed {
        logic [1:0]  status;
        logic        is_hit;
        logic [7:0]  set_number;
        logic [1:0]  way_number;
        logic [5:0]  line_offset;
        logic [6:0]  piece_length;
        logic [47:0] fill_line_index;
        logic [63:0] hit_total;
        logic [63:0] access_total;
        logic        last_piece;
    } piece_t;

    // The scoreboard holds a model of the tag store and the queue of pieces
    // that the engine still owes us.
    class tag_store_scoreboard;
        logic [1:0]  mode;
        logic [2:0]  les;
        logic [48:0] limit;
        bit          valid_bits[NSETS*NWAYS];
        logic [47:0] tags[NSETS*NWAYS];
        logic [15:0] uses[NSETS*NWAYS];
        logic [63:0] hits;
        logic [63:0] accesses;
        piece_t      owed_pieces[$];
        int          mismatches;
        int          pieces_seen;

        function void clear();
            mode = MODE_CACHE;
            les = 3'd0;
            limit = 49'h1_0000_0000_0000;
            foreach (valid_bits[i]) valid_bits[i] = 1'b0;
            hits = '0;
            accesses = '0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [48:0] data);
            if (idx == REG_MODE) mode = data[1:0];
            else if (idx == REG_LES) les = data[2:0];
            else if (idx == REG_LIMIT) limit = data;
        endfunction

        // Works out the pieces of one accepted run and queues them.
        function void note_run(logic [47:0] sidx, logic [6:0] rlen);
            logic [6:0]  len;
            logic [48:0] run_end;
            int          lls, elems, off, piece, set, way, base;
            logic [47:0] idx, tag, tmask;
            piece_t      p;
            len = (rlen > 7'd64) ? 7'd64 : rlen;
            accesses += 64'(len);
            run_end = 49'(sidx) + 49'(len);
            p = '0;
            p.last_piece = 1'b1;
            if (run_end > limit) begin
                p.status = ST_RANGE;
                p.hit_total = hits;
                p.access_total = accesses;
                owed_pieces.push_back(p);
                return;
            end
            if (mode == MODE_NONE || mode == MODE_RESIDENT) begin
                p.status = ST_BYPASS;
                p.piece_length = len;
                p.hit_total = hits;
                p.access_total = accesses;
                owed_pieces.push_back(p);
                return;
            end
            lls = (les > 3'd6) ? 0 : 6 - int'(les);
            elems = 1 << lls;
            tmask = ~((48'd1 << (lls + 8)) - 48'd1);
            idx = sidx;
            while (len != 0) begin
                off = int'(idx) & (elems - 1);
                piece = elems - off;
                if (piece > int'(len)) piece = int'(len);
                set = int'(idx >> lls) & (NSETS - 1);
                tag = idx & tmask;
                base = set * NWAYS;
                way = -1;
                for (int w = 0; w < NWAYS; w++)
                    if (way < 0 && valid_bits[base+w] && tags[base+w] == tag) way = w;
                p = '0;
                p.is_hit = (way >= 0);
                if (way >= 0) begin
                    hits += 64'(piece);
                    if (uses[base+way] != USE_MAX) uses[base+way]++;
                end else begin
                    // First empty way, otherwise the least used one.
                    for (int w = 0; w < NWAYS; w++)
                        if (way < 0 && !valid_bits[base+w]) way = w;
                    if (way < 0) begin
                        way = 0;
                        for (int w = 1; w < NWAYS; w++)
                            if (uses[base+w] < uses[base+way]) way = w;
                    end
                    valid_bits[base+way] = 1'b1;
                    tags[base+way] = tag;
                    uses[base+way] = '0;
                end
                len -= 7'(piece);
                p.status = ST_CACHED;
                p.set_number = 8'(set);
                p.way_number = 2'(way);
                p.line_offset = 6'(off);
                p.piece_length = 7'(piece);
                p.fill_line_index = idx & ~48'(elems - 1);
                p.hit_total = hits;
                p.access_total = accesses;
                p.last_piece = (len == 0);
                owed_pieces.push_back(p);
                idx = idx + 48'(piece);
            end
        endfunction

        function void check_piece(piece_t got);
            piece_t want;
            pieces_seen++;
            if (owed_pieces.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected result %p", got);
                return;
            end
            want = owed_pieces.pop_front();
            if (got != want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result mismatch\n  expected %p\n  actual   %p", want, got);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [48:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [47:0] start_index = '0;
    logic [6:0]  run_length = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic        is_hit;
    logic [7:0]  set_number;
    logic [1:0]  way_number;
    logic [5:0]  line_offset;
    logic [6:0]  piece_length;
    logic [47:0] fill_line_index;
    logic [63:0] hit_total;
    logic [63:0] access_total;
    logic        last_piece;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int runs_sent = 0;
    tag_store_scoreboard sb = new();

    set_assoc_lfu_cache_tag_engine i_dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // The receiver stalls at random; results are sampled at the edge where
    // the transfer happens, before the nonblocking updates land.
    always @(posedge clk)
    begin
        piece_t got;
        if (rst_n && out_valid && out_ready) begin
            got.status = status;
            got.is_hit = is_hit;
            got.set_number = set_number;
            got.way_number = way_number;
            got.line_offset = line_offset;
            got.piece_length = piece_length;
            got.fill_line_index = fill_line_index;
            got.hit_total = hit_total;
            got.access_total = access_total;
            got.last_piece = last_piece;
            sb.check_piece(got);
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Sends one run; the model is updated at the edge of the transfer.
    // Valid stays high after the transfer until the next run or an idle
    // cycle replaces it.
    task automatic send_run(logic [47:0] sidx, logic [6:0] rlen);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        start_index <= sidx;
        run_length <= rlen;
        do @(posedge clk); while (!in_ready);
        sb.note_run(sidx, rlen);
        runs_sent++;
    endtask

    // Waits for every owed piece, then a short pause so the engine is idle.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.owed_pieces.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [48:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random run: mostly near a small working set so sets fill, hit and
    // evict; sometimes anywhere, with occasional out-of-range lengths.
    task automatic random_run();
        logic [47:0] sidx;
        logic [6:0]  rlen;
        if ($urandom_range(9) < 7)
            sidx = 48'($urandom_range(4095)) | (48'($urandom_range(3)) << 14);
        else
            sidx = {16'($urandom), 32'($urandom)};
        rlen = ($urandom_range(19) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(1, 64));
        send_run(sidx, rlen);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        sb.clear();
        @(posedge clk);

        // Directed part at reset settings: extremes, hits, evictions.
        send_run(48'd0, 7'd1);
        send_run(48'd0, 7'd64);
        send_run(48'd63, 7'd2);
        send_run(48'hFFFF_FFFF_FFFF, 7'd1);
        send_run(48'hFFFF_FFFF_FFC0, 7'd64);
        send_run(48'd5, 7'd127);
        for (int t = 0; t < 6; t++)
            send_run(48'(t) << 14, 7'd3);
        send_run(48'd0, 7'd1);
        send_run(48'd0, 7'd0);
        drain();
        write_reg(REG_LIMIT, 49'd100);
        send_run(48'd99, 7'd1);
        send_run(48'd99, 7'd2);
        send_run(48'd101, 7'd0);
        drain();
        write_reg(REG_MODE, 49'(MODE_NONE));
        send_run(48'd10, 7'd20);
        drain();
        write_reg(REG_MODE, 49'(MODE_RESIDENT));
        send_run(48'd0, 7'd0);
        drain();
        write_reg(REG_MODE, 49'(MODE_SPARE));
        write_reg(REG_LES, 49'd7);
        write_reg(REG_LIMIT, 49'h1_FFFF_FFFF_FFFF);
        send_run(48'd300, 7'd5);
        drain();

        // Random phases, each with its own settings and idling pattern.
        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct = (ph < 2) ? 18 : (ph < 4) ? 57 : 0;
            recv_idle_pct = (ph < 2) ? 57 : (ph < 4) ? 18 : 0;
            write_reg(REG_MODE, (ph == 3) ? 49'(MODE_NONE) : 49'(MODE_CACHE));
            write_reg(REG_LES, 49'(ph + ph / 3));
            write_reg(REG_LIMIT, (ph == 2) ? 49'd3000 : 49'h1_0000_0000_0000);
            for (int n = 0; n < 14; n++) random_run();
            drain();
        end

        repeat (20) @(posedge clk);
        $display("Sent %0d runs and checked %0d results over all cache modes,", runs_sent,
                 sb.pieces_seen);
        $display("element sizes 1 to 128 bytes and several element limits.");
        if (sb.mismatches == 0 && sb.owed_pieces.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Verification failed");
        $finish;
    end
endmodule
